FILE: src/keyed_record_store_take_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the keyed record store
// Concurrent checks that compile to nothing when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef KEYED_RECORD_STORE_TAKE_MACROS_SVH
`define KEYED_RECORD_STORE_TAKE_MACROS_SVH

`ifndef NO_ASSERTIONS

// check outside reset
`define KRST_ASSERT(name, clock, reset, prop) \
  name: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error("krst: assertion failed");

// check at every edge, reset included
`define KRST_ASSERT_ALWAYS(name, clock, prop) \
  name: assert property (@(posedge clock) prop) \
    else $error("krst: assertion failed");

`else

`define KRST_ASSERT(name, clock, reset, prop)
`define KRST_ASSERT_ALWAYS(name, clock, prop)

`endif

`endif

FILE: src/krst_pkg.sv
// ----------------------------------------------------------------------------
// Keyed record store package
// Sizes, codes and payload types shared by the store's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package krst_pkg;

  localparam int unsigned SLOT_COUNT  = 64;
  localparam int unsigned SLOT_IDX_W  = $clog2(SLOT_COUNT);
  localparam int unsigned VALUE_WORDS = 4;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    REQ_STORE = 1'b0,
    REQ_TAKE  = 1'b1
  } req_type_t;

  typedef enum logic [2:0] {
    ST_NEW       = 3'd0,
    ST_OVERWRITE = 3'd1,
    ST_FULL      = 3'd2,
    ST_TAKEN     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    req_type_t   req_type;
    logic [63:0] peer_key;
    logic [63:0] first_word0;
    logic [63:0] first_word1;
    logic [63:0] first_word2;
    logic [63:0] first_word3;
    logic [63:0] second_word0;
    logic [63:0] second_word1;
    logic [63:0] second_word2;
    logic [63:0] second_word3;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] out_first0;
    logic [63:0] out_first1;
    logic [63:0] out_first2;
    logic [63:0] out_first3;
    logic [63:0] out_second0;
    logic [63:0] out_second1;
    logic [63:0] out_second2;
    logic [63:0] out_second3;
  } rsp_t;

  typedef struct packed {
    logic [VALUE_WORDS-1:0][WORD_W-1:0] second;
    logic [VALUE_WORDS-1:0][WORD_W-1:0] first;
  } record_t;

  localparam int unsigned RECORD_W = $bits(record_t);

  typedef struct packed {
    req_type_t        kind;
    logic [KEY_W-1:0] key;
    record_t          rec;
  } job_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_MATCH,
    BS_ENCODE,
    BS_EXEC,
    BS_READ
  } back_state_t;

endpackage

`default_nettype wire

FILE: src/krst_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module krst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/krst_front.sv
// ----------------------------------------------------------------------------
// Keyed record store front end
// Accepts requests, turns them into store and take jobs and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module krst_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire krst_pkg::req_t  req,
  output logic                 job_valid,
  input  wire logic            job_pop,
  output krst_pkg::job_t       job
);

  localparam int unsigned PTR_W = $clog2(krst_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(krst_pkg::QUEUE_DEPTH + 1);

  krst_pkg::job_t   entries [krst_pkg::QUEUE_DEPTH];
  krst_pkg::job_t   job_in;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign req_stall = (count == CNT_W'(krst_pkg::QUEUE_DEPTH));
  assign job_valid = (count != '0);
  assign job       = entries[rd_ptr];
  assign push      = req_valid && !req_stall;
  assign pop       = job_pop && job_valid;

  always_comb begin
    job_in.kind          = req.req_type;
    job_in.key           = req.peer_key;
    job_in.rec.first[0]  = req.first_word0;
    job_in.rec.first[1]  = req.first_word1;
    job_in.rec.first[2]  = req.first_word2;
    job_in.rec.first[3]  = req.first_word3;
    job_in.rec.second[0] = req.second_word0;
    job_in.rec.second[1] = req.second_word1;
    job_in.rec.second[2] = req.second_word2;
    job_in.rec.second[3] = req.second_word3;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(krst_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(krst_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/krst_back.sv
// ----------------------------------------------------------------------------
// Keyed record store back end
// Matches keys over the slot cells, updates slots and the record RAM, and
// holds each result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "keyed_record_store_take_macros.svh"

module krst_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            job_valid,
  output logic                 job_pop,
  input  wire krst_pkg::job_t  job,
  output logic                 rsp_valid,
  input  wire logic            rsp_stall,
  output krst_pkg::rsp_t       rsp
);

  localparam int unsigned IDX_W = krst_pkg::SLOT_IDX_W;

  krst_pkg::back_state_t state;
  krst_pkg::back_state_t state_next;
  krst_pkg::job_t        cur;
  krst_pkg::rsp_t        rsp_next;
  krst_pkg::record_t     rd_rec;

  logic [krst_pkg::SLOT_COUNT-1:0] slot_valid;
  logic [krst_pkg::KEY_W-1:0]      slot_key [krst_pkg::SLOT_COUNT];
  logic [krst_pkg::SLOT_COUNT-1:0] cmp_vec;
  logic [krst_pkg::SLOT_COUNT-1:0] match_vec;
  logic [krst_pkg::SLOT_COUNT-1:0] free_vec;
  logic                            hit;
  logic [IDX_W-1:0]                hit_idx;
  logic                            free_any;
  logic [IDX_W-1:0]                free_idx;
  logic [IDX_W-1:0]                target;
  logic                            rsp_free;
  logic                            rsp_load;
  logic                            valid_set;
  logic                            valid_clr;
  logic                            ram_we;
  logic [krst_pkg::RECORD_W-1:0]   ram_rdata;

  function automatic logic [IDX_W:0] first_set(input logic [krst_pkg::SLOT_COUNT-1:0] vec);
    logic [IDX_W:0] res;
    res = '0;
    for (int i = krst_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
      if (vec[i]) begin
        res = {1'b1, IDX_W'(i)};
      end
    end
    return res;
  endfunction

  krst_ram #(
    .WIDTH (krst_pkg::RECORD_W),
    .DEPTH (krst_pkg::SLOT_COUNT)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (target),
    .wdata (cur.rec),
    .raddr (hit_idx),
    .rdata (ram_rdata)
  );

  assign rd_rec   = krst_pkg::record_t'(ram_rdata);
  assign rsp_free = !rsp_valid || !rsp_stall;
  assign target   = hit ? hit_idx : free_idx;

  always_comb begin
    for (int i = 0; i < krst_pkg::SLOT_COUNT; i++) begin
      cmp_vec[i] = slot_valid[i] && (slot_key[i] == cur.key);
    end
  end

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    rsp_load   = 1'b0;
    rsp_next   = '0;
    valid_set  = 1'b0;
    valid_clr  = 1'b0;
    ram_we     = 1'b0;
    case (state)
      krst_pkg::BS_IDLE: begin
        if (job_valid && rsp_free) begin
          job_pop    = 1'b1;
          state_next = krst_pkg::BS_MATCH;
        end
      end
      krst_pkg::BS_MATCH: begin
        state_next = krst_pkg::BS_ENCODE;
      end
      krst_pkg::BS_ENCODE: begin
        state_next = krst_pkg::BS_EXEC;
      end
      krst_pkg::BS_EXEC: begin
        if (cur.kind == krst_pkg::REQ_STORE) begin
          rsp_load   = 1'b1;
          state_next = krst_pkg::BS_IDLE;
          if (hit) begin
            ram_we          = 1'b1;
            rsp_next.status = krst_pkg::ST_OVERWRITE;
          end else if (free_any) begin
            ram_we          = 1'b1;
            valid_set       = 1'b1;
            rsp_next.status = krst_pkg::ST_NEW;
          end else begin
            rsp_next.status = krst_pkg::ST_FULL;
          end
        end else if (hit) begin
          valid_clr  = 1'b1;
          state_next = krst_pkg::BS_READ;
        end else begin
          rsp_load        = 1'b1;
          rsp_next.status = krst_pkg::ST_NOT_FOUND;
          state_next      = krst_pkg::BS_IDLE;
        end
      end
      krst_pkg::BS_READ: begin
        rsp_load             = 1'b1;
        rsp_next.status      = krst_pkg::ST_TAKEN;
        rsp_next.out_first0  = rd_rec.first[0];
        rsp_next.out_first1  = rd_rec.first[1];
        rsp_next.out_first2  = rd_rec.first[2];
        rsp_next.out_first3  = rd_rec.first[3];
        rsp_next.out_second0 = rd_rec.second[0];
        rsp_next.out_second1 = rd_rec.second[1];
        rsp_next.out_second2 = rd_rec.second[2];
        rsp_next.out_second3 = rd_rec.second[3];
        state_next           = krst_pkg::BS_IDLE;
      end
      default: begin
        state_next = krst_pkg::BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= krst_pkg::BS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur <= job;
    end
    if (state == krst_pkg::BS_MATCH) begin
      match_vec <= cmp_vec;
      free_vec  <= ~slot_valid;
    end
    if (state == krst_pkg::BS_ENCODE) begin
      {hit, hit_idx}      <= first_set(match_vec);
      {free_any, free_idx} <= first_set(free_vec);
    end
    if (valid_set) begin
      slot_key[target] <= cur.key;
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else begin
      if (valid_set) begin
        slot_valid[target] <= 1'b1;
      end
      if (valid_clr) begin
        slot_valid[hit_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  `KRST_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (state == krst_pkg::BS_IDLE) && !rsp_valid)
  `KRST_ASSERT(a_exec_rsp_empty, clk, rst, (state == krst_pkg::BS_EXEC) |-> !rsp_valid)
  `KRST_ASSERT(a_key_unique, clk, rst, (state == krst_pkg::BS_ENCODE) |-> $countones(match_vec) <= 1)
  `KRST_ASSERT(a_new_grows, clk, rst, valid_set |=> $countones(slot_valid) == $past($countones(slot_valid)) + 1)
  `KRST_ASSERT(a_take_shrinks, clk, rst, valid_clr |=> $countones(slot_valid) + 1 == $past($countones(slot_valid)))

endmodule

`default_nettype wire

FILE: src/keyed_record_store_take.sv
// ----------------------------------------------------------------------------
// Keyed record store with take: each job passes the back-end states MATCH, ENCODE
// and EXEC, a take that hits also READ; the back end works on one job at a time.
// Reset empties the queue and frees every slot at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_record_store_take (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire krst_pkg::req_t  req,
  output logic                 rsp_valid,
  input  wire logic            rsp_stall,
  output krst_pkg::rsp_t       rsp
);

  logic           job_valid;
  logic           job_pop;
  krst_pkg::job_t job;

  krst_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job       (job)
  );

  krst_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job       (job),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed record store with take: self-checking bench
// Drives store and take requests through the valid/stall request port and
// checks every result against a behavioural store of keys and records kept
// here. Both ports idle and stall at random. A short directed table comes
// first, then random phases that fill the store to overflow, drain it and
// mix stores and takes over a small pool of keys.
// ----------------------------------------------------------------------------

module tb_top;
  import krst_pkg::*;

  localparam int RANDOM_ITEMS = 500;
  localparam int POOL_KEYS    = 48;
  localparam int SETTLE       = 20;

  typedef enum int {
    PH_MIXED,
    PH_FILL,
    PH_DRAIN,
    PH_PAIRS
  } phase_t;

  typedef struct {
    req_t rq;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  bit          occupied   [SLOT_COUNT];
  logic [63:0] held_key   [SLOT_COUNT];
  logic [255:0] held_first [SLOT_COUNT];
  logic [255:0] held_second[SLOT_COUNT];

  rsp_t  pending[$];
  int    failures = 0;
  int    sent_total = 0;
  int    stores_sent = 0;
  int    takes_sent = 0;
  int    status_tally[5] = '{default: 0};
  int    sink_hold = 0;
  bit    quiet_src = 1'b0;
  bit    quiet_dst = 1'b0;
  string word_name[8] = '{"out_first0", "out_first1", "out_first2", "out_first3",
                          "out_second0", "out_second1", "out_second2", "out_second3"};

  keyed_record_store_take i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  function automatic req_t mk_req(req_type_t kind, logic [63:0] key,
                                  logic [255:0] f, logic [255:0] s);
    req_t r;
    r.req_type     = kind;
    r.peer_key     = key;
    r.first_word0  = f[63:0];
    r.first_word1  = f[127:64];
    r.first_word2  = f[191:128];
    r.first_word3  = f[255:192];
    r.second_word0 = s[63:0];
    r.second_word1 = s[127:64];
    r.second_word2 = s[191:128];
    r.second_word3 = s[255:192];
    return r;
  endfunction

  function automatic rsp_t mk_rsp(status_t st, logic [255:0] f, logic [255:0] s);
    rsp_t r;
    r.status      = st;
    r.out_first0  = f[63:0];
    r.out_first1  = f[127:64];
    r.out_first2  = f[191:128];
    r.out_first3  = f[255:192];
    r.out_second0 = s[63:0];
    r.out_second1 = s[127:64];
    r.out_second2 = s[191:128];
    r.out_second3 = s[255:192];
    return r;
  endfunction

  function automatic dir_row_t dir_row(req_t rq, bit typed, rsp_t want);
    dir_row_t d;
    d.rq    = rq;
    d.typed = typed;
    d.want  = want;
    return d;
  endfunction

  function automatic logic [63:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [255:0] rand256();
    logic [255:0] v;
    for (int i = 0; i < 8; i++) v[32*i +: 32] = $urandom;
    return v;
  endfunction

  function automatic int occupancy();
    int n;
    n = 0;
    for (int i = 0; i < SLOT_COUNT; i++) n += occupied[i];
    return n;
  endfunction

  function automatic logic [63:0] pick_held_key(output bit got);
    int idx[$];
    for (int i = 0; i < SLOT_COUNT; i++) if (occupied[i]) idx.push_back(i);
    got = idx.size() > 0;
    return got ? held_key[idx[$urandom_range(0, idx.size() - 1)]] : 64'd0;
  endfunction

  // result of one request; updates the held records
  function automatic rsp_t predict_store_take(req_t r);
    rsp_t         res;
    int           hit;
    int           vacant;
    logic [255:0] f;
    logic [255:0] s;
    hit    = -1;
    vacant = -1;
    f = {r.first_word3, r.first_word2, r.first_word1, r.first_word0};
    s = {r.second_word3, r.second_word2, r.second_word1, r.second_word0};
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (occupied[i] && held_key[i] == r.peer_key) hit = i;
      if (!occupied[i]) vacant = i;
    end
    if (r.req_type == REQ_STORE) begin
      if (hit >= 0) begin
        held_first[hit]  = f;
        held_second[hit] = s;
        res = mk_rsp(ST_OVERWRITE, '0, '0);
      end else if (vacant >= 0) begin
        occupied[vacant]    = 1'b1;
        held_key[vacant]    = r.peer_key;
        held_first[vacant]  = f;
        held_second[vacant] = s;
        res = mk_rsp(ST_NEW, '0, '0);
      end else begin
        res = mk_rsp(ST_FULL, '0, '0);
      end
    end else if (hit >= 0) begin
      res = mk_rsp(ST_TAKEN, held_first[hit], held_second[hit]);
      occupied[hit] = 1'b0;
    end else begin
      res = mk_rsp(ST_NOT_FOUND, '0, '0);
    end
    return res;
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_req(input req_t r, input bit typed, input rsp_t typed_rsp);
    int   gap;
    rsp_t want;
    gap = quiet_src ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    want = predict_store_take(r);
    pending.push_back(typed ? typed_rsp : want);
    sent_total++;
    if (r.req_type == REQ_STORE) stores_sent++;
    else takes_sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rsp_valid && sink_hold > 0) begin
      rsp_stall <= 1'b1;
      sink_hold = sink_hold - 1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $time, rsp.status);
        failures++;
      end else begin
        want = pending.pop_front();
        if (rsp.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, rsp.status);
          failures++;
        end
        for (int w = 0; w < 8; w++) begin
          if (rsp[511-64*w -: 64] !== want[511-64*w -: 64]) begin
            $display("%0t: %s expected %h got %h", $time, word_name[w],
                     want[511-64*w -: 64], rsp[511-64*w -: 64]);
            failures++;
          end
        end
      end
      if (int'(rsp.status) <= int'(ST_NOT_FOUND)) status_tally[int'(rsp.status)]++;
      sink_hold = quiet_dst ? 0 : $urandom_range(0, 19);
    end
  end

  initial begin
    dir_row_t     dir_tab[$];
    logic [63:0]  key_pool[POOL_KEYS];
    logic [255:0] ones;
    logic [255:0] pat_a;
    logic [255:0] pat_b;
    logic [63:0]  k_mid;
    logic [63:0]  key;
    bit           got;
    int           iter;
    int           n;
    int           coin;
    phase_t       ph;

    ones  = '1;
    pat_a = {4{64'hA5A5_5A5A_0F0F_F0F0}};
    pat_b = {4{64'h3C3C_C3C3_9669_6996}};
    k_mid = 64'h8000_0000_0000_0001;
    for (int i = 0; i < POOL_KEYS; i++) key_pool[i] = rand_key();

    dir_tab.push_back(dir_row(mk_req(REQ_TAKE, 64'd0, '0, '0), 1,
                              mk_rsp(ST_NOT_FOUND, '0, '0)));
    dir_tab.push_back(dir_row(mk_req(REQ_STORE, 64'd0, ones, '0), 1,
                              mk_rsp(ST_NEW, '0, '0)));
    dir_tab.push_back(dir_row(mk_req(REQ_STORE, '1, '0, ones), 1,
                              mk_rsp(ST_NEW, '0, '0)));
    dir_tab.push_back(dir_row(mk_req(REQ_TAKE, k_mid, ones, ones), 1,
                              mk_rsp(ST_NOT_FOUND, '0, '0)));
    dir_tab.push_back(dir_row(mk_req(REQ_STORE, 64'd0, pat_a, pat_b), 1,
                              mk_rsp(ST_OVERWRITE, '0, '0)));
    dir_tab.push_back(dir_row(mk_req(REQ_TAKE, 64'd0, '0, '0), 1,
                              mk_rsp(ST_TAKEN, pat_a, pat_b)));
    dir_tab.push_back(dir_row(mk_req(REQ_TAKE, 64'd0, ones, ones), 1,
                              mk_rsp(ST_NOT_FOUND, '0, '0)));
    dir_tab.push_back(dir_row(mk_req(REQ_STORE, k_mid, pat_b, pat_a), 1,
                              mk_rsp(ST_NEW, '0, '0)));
    dir_tab.push_back(dir_row(mk_req(REQ_TAKE, '1, ones, ones), 1,
                              mk_rsp(ST_TAKEN, '0, ones)));
    dir_tab.push_back(dir_row(mk_req(REQ_STORE, '1, ones, ones), 1,
                              mk_rsp(ST_NEW, '0, '0)));
    dir_tab.push_back(dir_row(mk_req(REQ_STORE, k_mid, rand256(), rand256()), 0, '0));
    dir_tab.push_back(dir_row(mk_req(REQ_TAKE, k_mid, rand256(), rand256()), 0, '0));
    dir_tab.push_back(dir_row(mk_req(REQ_TAKE, '1, '0, '0), 1,
                              mk_rsp(ST_TAKEN, ones, ones)));
    dir_tab.push_back(dir_row(mk_req(REQ_STORE, rand_key(), rand256(), rand256()), 0, '0));
    dir_tab.push_back(dir_row(mk_req(REQ_TAKE, k_mid, '0, '0), 1,
                              mk_rsp(ST_NOT_FOUND, '0, '0)));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[i]) send_req(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].want);

    iter = 0;
    while (sent_total - dir_tab.size() < RANDOM_ITEMS) begin
      quiet_src = ($urandom_range(0, 3) == 0);
      quiet_dst = ($urandom_range(0, 3) == 0);
      if (iter == 0) ph = PH_FILL;
      else if (iter == 1) ph = PH_DRAIN;
      else ph = phase_t'($urandom_range(0, 3));
      iter++;
      case (ph)
        PH_FILL: begin
          while (occupancy() < SLOT_COUNT)
            send_req(mk_req(REQ_STORE, rand_key(), rand256(), rand256()), 0, '0);
          repeat ($urandom_range(1, 4))
            send_req(mk_req(REQ_STORE, rand_key(), rand256(), rand256()), 0, '0);
          key = pick_held_key(got);
          send_req(mk_req(REQ_STORE, key, rand256(), rand256()), 0, '0);
          key = pick_held_key(got);
          send_req(mk_req(REQ_TAKE, key, rand256(), rand256()), 0, '0);
          send_req(mk_req(REQ_STORE, rand_key(), rand256(), rand256()), 0, '0);
        end
        PH_DRAIN: begin
          n = $urandom_range(10, 70);
          repeat (n) begin
            key = pick_held_key(got);
            if (!got || $urandom_range(0, 4) == 0) key = rand_key();
            send_req(mk_req(REQ_TAKE, key, rand256(), rand256()), 0, '0);
          end
        end
        PH_PAIRS: begin
          repeat (10) begin
            key = ($urandom_range(0, 1) == 0) ? rand_key()
                                               : key_pool[$urandom_range(0, POOL_KEYS - 1)];
            send_req(mk_req(REQ_STORE, key, rand256(), rand256()), 0, '0);
            send_req(mk_req(REQ_TAKE, key, rand256(), rand256()), 0, '0);
          end
        end
        default: begin
          repeat (30) begin
            coin = $urandom_range(0, 9);
            key  = key_pool[$urandom_range(0, POOL_KEYS - 1)];
            if (coin <= 4) begin
              send_req(mk_req(REQ_STORE, key, rand256(), rand256()), 0, '0);
            end else if (coin <= 7) begin
              send_req(mk_req(REQ_TAKE, key, rand256(), rand256()), 0, '0);
            end else if (coin == 8) begin
              key = pick_held_key(got);
              send_req(mk_req(REQ_TAKE, key, rand256(), rand256()), 0, '0);
            end else begin
              send_req(mk_req(req_type_t'($urandom_range(0, 1)), rand_key(),
                              rand256(), rand256()), 0, '0);
            end
          end
        end
      endcase
    end

    req_valid <= 1'b0;
    while (pending.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (pending.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending.size());
      failures++;
    end

    $display("Sent %0d requests: %0d stores, %0d takes, %0d from the directed table",
             sent_total, stores_sent, takes_sent, dir_tab.size());
    $display("Results: %0d new, %0d overwritten, %0d full, %0d taken, %0d not found",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4]);
    if (failures == 0) begin
      $display("[keyed_record_store_take] OK");
    end else begin
      $display("[keyed_record_store_take] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout, %0d results outstanding", $time, pending.size());
    $display("[keyed_record_store_take] ERROR");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/krst_pkg.sv
src/krst_ram.sv
src/krst_front.sv
src/krst_back.sv
src/keyed_record_store_take.sv
sim/tb_top.sv
